### sv/linear_congruence_solver_defines.svh
// -----------------------------------------------------------------------------
// Linear congruence solver assertion macros
// Shared macros for the concurrent assertions of the solver checker.
// -----------------------------------------------------------------------------
`ifndef LINEAR_CONGRUENCE_SOLVER_DEFINES_SVH
`define LINEAR_CONGRUENCE_SOLVER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define LCS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define LCS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/lcs_pkg.sv
// -----------------------------------------------------------------------------
// Linear congruence solver package
// Widths, sequencer states and the request and response structs shared by
// the solver modules.
// -----------------------------------------------------------------------------
package lcs_pkg;

  // Operand width of multiplier, modulus and results.
  localparam int unsigned OpndW = 32;
  // Dividend width of the shared divider: covers the target magnitude 2^OpndW.
  localparam int unsigned DivW = OpndW + 1;
  // Signed width of the Bezout coefficients and their partial products.
  localparam int unsigned CoefW = OpndW + 3;
  localparam int unsigned DivCntW = $clog2(DivW + 1);
  localparam int unsigned MulCntW = $clog2(OpndW + 1);

  typedef logic [OpndW-1:0] opnd_t;
  typedef logic [DivW-1:0] wide_t;
  typedef logic signed [CoefW-1:0] coef_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EUC_DIV,
    ST_CHK_DIV,
    ST_NP_DIV,
    ST_SMOD_DIV,
    ST_BMOD_DIV,
    ST_MUL,
    ST_OUT
  } lcs_state_e;

  // Divider command: dividend / divisor, with quotient * mac_op formed alongside.
  typedef struct packed {
    logic  start;
    wide_t dividend;
    opnd_t divisor;
    coef_t mac_op;
  } div_req_t;

  typedef struct packed {
    logic  done;
    wide_t quotient;
    opnd_t remainder;
    coef_t product;
  } div_rsp_t;

  // Modular multiplier command: (x * y) mod m with x, y < m.
  typedef struct packed {
    logic  start;
    opnd_t x;
    opnd_t y;
    opnd_t m;
  } mul_req_t;

  typedef struct packed {
    logic  done;
    opnd_t result;
  } mul_rsp_t;

endpackage

### sv/lcs_in_if.sv
// -----------------------------------------------------------------------------
// Linear congruence solver input channel
// Valid/ready channel that carries one congruence a*x = b (mod n).
// -----------------------------------------------------------------------------
interface lcs_in_if;

  logic                       valid;
  logic                       ready;
  logic [lcs_pkg::OpndW-1:0]  multiplier;
  logic signed [lcs_pkg::OpndW:0] target;
  logic [lcs_pkg::OpndW-1:0]  modulus;

  modport source (output valid, output multiplier, output target, output modulus,
                  input ready);
  modport sink (input valid, input multiplier, input target, input modulus,
                output ready);

endinterface

### sv/lcs_out_if.sv
// -----------------------------------------------------------------------------
// Linear congruence solver output channel
// Valid/ready channel that carries the solution of one congruence.
// -----------------------------------------------------------------------------
interface lcs_out_if;

  logic                      valid;
  logic                      ready;
  logic                      solvable;
  logic [lcs_pkg::OpndW-1:0] solution;
  logic [lcs_pkg::OpndW-1:0] divisor;

  modport source (output valid, output solvable, output solution, output divisor,
                  input ready);
  modport sink (input valid, input solvable, input solution, input divisor,
                output ready);

endinterface

### sv/lcs_divider.sv
// -----------------------------------------------------------------------------
// Linear congruence solver divider
// Restoring divider, one quotient bit per cycle, that also forms the product
// of the quotient and a signed coefficient by Horner accumulation.
// -----------------------------------------------------------------------------
module lcs_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lcs_pkg::div_req_t req_i,
  output lcs_pkg::div_rsp_t rsp_o
);

  logic                         busy_q;
  logic                         done_q;
  logic [lcs_pkg::DivCntW-1:0]  cnt_q;
  lcs_pkg::opnd_t               rem_q;
  lcs_pkg::wide_t               quo_q;
  lcs_pkg::opnd_t               dsr_q;
  lcs_pkg::coef_t               mop_q;
  lcs_pkg::coef_t               acc_q;

  logic [lcs_pkg::OpndW:0]      trial;
  logic [lcs_pkg::OpndW:0]      diff;
  logic                         fits;
  lcs_pkg::opnd_t               rem_d;
  lcs_pkg::coef_t               acc_d;
  logic                         last;

  // One restoring step: shift in the next dividend bit and try the subtract.
  always_comb begin
    trial = {rem_q, quo_q[lcs_pkg::DivW-1]};
    diff  = trial - {1'b0, dsr_q};
    fits  = (trial >= {1'b0, dsr_q});
    rem_d = fits ? diff[lcs_pkg::OpndW-1:0] : trial[lcs_pkg::OpndW-1:0];
    acc_d = (acc_q <<< 1) + (fits ? mop_q : '0);
    last  = (cnt_q == lcs_pkg::DivCntW'(lcs_pkg::DivW - 1));
  end

  // Control: busy flag, bit counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: operands latch at start, then iterate while busy.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
      mop_q <= req_i.mac_op;
      acc_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[lcs_pkg::DivW-2:0], fits};
      acc_q <= acc_d;
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;
  assign rsp_o.product   = acc_q;

endmodule

### sv/lcs_mulmod.sv
// -----------------------------------------------------------------------------
// Linear congruence solver modular multiplier
// Shift-and-add multiplier that keeps the product and the doubled operand
// reduced modulo m, one multiplier bit per cycle.
// -----------------------------------------------------------------------------
module lcs_mulmod (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lcs_pkg::mul_req_t req_i,
  output lcs_pkg::mul_rsp_t rsp_o
);

  logic                         busy_q;
  logic                         done_q;
  logic [lcs_pkg::MulCntW-1:0]  cnt_q;
  lcs_pkg::opnd_t               acc_q;
  lcs_pkg::opnd_t               x_q;
  lcs_pkg::opnd_t               y_q;
  lcs_pkg::opnd_t               m_q;

  logic [lcs_pkg::OpndW:0]      acc_sum;
  logic [lcs_pkg::OpndW:0]      x_sum;
  lcs_pkg::opnd_t               acc_d;
  lcs_pkg::opnd_t               x_d;
  logic                         last;

  // Both sums stay below 2m, so one conditional subtract reduces them.
  always_comb begin
    acc_sum = {1'b0, acc_q} + {1'b0, x_q};
    x_sum   = {1'b0, x_q} + {1'b0, x_q};
    if (acc_sum >= {1'b0, m_q}) begin
      acc_d = lcs_pkg::OpndW'(acc_sum - {1'b0, m_q});
    end else begin
      acc_d = acc_sum[lcs_pkg::OpndW-1:0];
    end
    if (x_sum >= {1'b0, m_q}) begin
      x_d = lcs_pkg::OpndW'(x_sum - {1'b0, m_q});
    end else begin
      x_d = x_sum[lcs_pkg::OpndW-1:0];
    end
    last = (cnt_q == lcs_pkg::MulCntW'(lcs_pkg::OpndW - 1));
  end

  // Control: busy flag, bit counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: add the doubled operand where the multiplier bit is set.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= '0;
      x_q   <= req_i.x;
      y_q   <= req_i.y;
      m_q   <= req_i.m;
    end else if (busy_q) begin
      if (y_q[0]) begin
        acc_q <= acc_d;
      end
      x_q <= x_d;
      y_q <= y_q >> 1;
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = acc_q;

endmodule

### sv/linear_congruence_solver.sv
// -----------------------------------------------------------------------------
// Linear congruence solver
// Solves multiplier * x = target (mod modulus) with the extended Euclidean
// algorithm on a shared bit-serial divider and a modular multiplier.
// -----------------------------------------------------------------------------
// One transaction is taken at a time: the input is ready only while the block
// is idle, and a result is held until the output transaction completes. Every
// division runs on one shared restoring divider, which is launched, forms the
// 33 quotient bits one at a time and then hands back the result; an item needs
// one division per Euclid step (up to about 47 for 32-bit operands) plus four
// more for the divisibility check and the reductions modulo n/g, then one pass
// through the modular multiplier. A zero modulus goes straight to the output
// with no division, and an unsolvable item leaves after the check.
module linear_congruence_solver (
  input  logic        clk_i,
  input  logic        rst_ni,
  lcs_in_if.sink      in_i,
  lcs_out_if.source   out_o
);

  lcs_pkg::lcs_state_e state_q, state_d;
  logic                launched_q;

  lcs_pkg::opnd_t      r_prev_q;
  lcs_pkg::opnd_t      r_cur_q;
  lcs_pkg::coef_t      s_prev_q;
  lcs_pkg::coef_t      s_cur_q;
  lcs_pkg::opnd_t      n_q;
  logic                bneg_q;
  lcs_pkg::wide_t      bmag_q;
  lcs_pkg::wide_t      bq_q;
  lcs_pkg::opnd_t      np_q;
  lcs_pkg::opnd_t      smod_q;
  logic                solv_q;
  lcs_pkg::opnd_t      sol_q;
  lcs_pkg::opnd_t      gcd_q;

  lcs_pkg::div_req_t   div_req;
  lcs_pkg::div_rsp_t   div_rsp;
  lcs_pkg::mul_req_t   mul_req;
  lcs_pkg::mul_rsp_t   mul_rsp;

  logic                in_take;
  logic                div_state;
  logic                div_start;
  logic                mul_start;
  lcs_pkg::wide_t      s_abs;
  lcs_pkg::opnd_t      smod_d;
  lcs_pkg::opnd_t      bmod_d;
  lcs_pkg::wide_t      in_bmag;

  lcs_divider u_lcs_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  lcs_mulmod u_lcs_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      lcs_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          state_d = (in_i.modulus == '0) ? lcs_pkg::ST_OUT : lcs_pkg::ST_EUC_DIV;
        end
      end
      lcs_pkg::ST_EUC_DIV: begin
        if (div_rsp.done && (div_rsp.remainder == '0)) begin
          state_d = lcs_pkg::ST_CHK_DIV;
        end
      end
      lcs_pkg::ST_CHK_DIV: begin
        if (div_rsp.done) begin
          state_d = (div_rsp.remainder != '0) ? lcs_pkg::ST_OUT : lcs_pkg::ST_NP_DIV;
        end
      end
      lcs_pkg::ST_NP_DIV: begin
        if (div_rsp.done) begin
          state_d = lcs_pkg::ST_SMOD_DIV;
        end
      end
      lcs_pkg::ST_SMOD_DIV: begin
        if (div_rsp.done) begin
          state_d = lcs_pkg::ST_BMOD_DIV;
        end
      end
      lcs_pkg::ST_BMOD_DIV: begin
        if (div_rsp.done) begin
          state_d = lcs_pkg::ST_MUL;
        end
      end
      lcs_pkg::ST_MUL: begin
        if (mul_rsp.done) begin
          state_d = lcs_pkg::ST_OUT;
        end
      end
      lcs_pkg::ST_OUT: begin
        if (out_o.ready) begin
          state_d = lcs_pkg::ST_IDLE;
        end
      end
      default: state_d = lcs_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshakes and unit launches.
  always_comb begin
    in_i.ready  = 1'b0;
    out_o.valid = 1'b0;
    div_state   = 1'b0;
    case (state_q)
      lcs_pkg::ST_IDLE:     in_i.ready  = 1'b1;
      lcs_pkg::ST_EUC_DIV:  div_state   = 1'b1;
      lcs_pkg::ST_CHK_DIV:  div_state   = 1'b1;
      lcs_pkg::ST_NP_DIV:   div_state   = 1'b1;
      lcs_pkg::ST_SMOD_DIV: div_state   = 1'b1;
      lcs_pkg::ST_BMOD_DIV: div_state   = 1'b1;
      lcs_pkg::ST_OUT:      out_o.valid = 1'b1;
      default: begin
        in_i.ready  = 1'b0;
        out_o.valid = 1'b0;
      end
    endcase
    div_start = div_state && !launched_q;
    mul_start = (state_q == lcs_pkg::ST_BMOD_DIV) && div_rsp.done;
  end

  assign in_take = in_i.valid && in_i.ready;

  // Divider operand selection, one division per sequencer state.
  always_comb begin
    s_abs = s_prev_q[lcs_pkg::CoefW-1] ? lcs_pkg::DivW'(-s_prev_q)
                                       : lcs_pkg::DivW'(s_prev_q);
    div_req.start    = div_start;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    div_req.mac_op   = '0;
    case (state_q)
      lcs_pkg::ST_EUC_DIV: begin
        div_req.dividend = {1'b0, r_prev_q};
        div_req.divisor  = r_cur_q;
        div_req.mac_op   = s_cur_q;
      end
      lcs_pkg::ST_CHK_DIV: begin
        div_req.dividend = bmag_q;
        div_req.divisor  = r_prev_q;
      end
      lcs_pkg::ST_NP_DIV: begin
        div_req.dividend = {1'b0, n_q};
        div_req.divisor  = r_prev_q;
      end
      lcs_pkg::ST_SMOD_DIV: begin
        div_req.dividend = s_abs;
        div_req.divisor  = np_q;
      end
      lcs_pkg::ST_BMOD_DIV: begin
        div_req.dividend = bq_q;
        div_req.divisor  = np_q;
      end
      default: div_req.dividend = '0;
    endcase
  end

  // Residues folded into [0, n/g) with the signs of s and the target.
  always_comb begin
    if (s_prev_q[lcs_pkg::CoefW-1] && (div_rsp.remainder != '0)) begin
      smod_d = np_q - div_rsp.remainder;
    end else begin
      smod_d = div_rsp.remainder;
    end
    if (bneg_q && (div_rsp.remainder != '0)) begin
      bmod_d = np_q - div_rsp.remainder;
    end else begin
      bmod_d = div_rsp.remainder;
    end
    in_bmag = in_i.target[lcs_pkg::OpndW] ? lcs_pkg::DivW'(-in_i.target)
                                          : lcs_pkg::DivW'(in_i.target);
  end

  assign mul_req.start = mul_start;
  assign mul_req.x     = smod_q;
  assign mul_req.y     = bmod_d;
  assign mul_req.m     = np_q;

  // Sequencer state and the divider launch flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= lcs_pkg::ST_IDLE;
      launched_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (div_start) begin
        launched_q <= 1'b1;
      end else if (div_rsp.done) begin
        launched_q <= 1'b0;
      end
    end
  end

  // Euclid registers, intermediate residues and the result register.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      r_prev_q <= in_i.multiplier;
      r_cur_q  <= in_i.modulus;
      s_prev_q <= lcs_pkg::CoefW'(1);
      s_cur_q  <= '0;
      n_q      <= in_i.modulus;
      bneg_q   <= in_i.target[lcs_pkg::OpndW];
      bmag_q   <= in_bmag;
      solv_q   <= 1'b0;
      sol_q    <= '0;
      gcd_q    <= '0;
    end
    case (state_q)
      lcs_pkg::ST_EUC_DIV: begin
        if (div_rsp.done) begin
          r_prev_q <= r_cur_q;
          r_cur_q  <= div_rsp.remainder;
          s_prev_q <= s_cur_q;
          s_cur_q  <= s_prev_q - div_rsp.product;
        end
      end
      lcs_pkg::ST_CHK_DIV: begin
        if (div_rsp.done) begin
          bq_q  <= div_rsp.quotient;
          gcd_q <= r_prev_q;
        end
      end
      lcs_pkg::ST_NP_DIV: begin
        if (div_rsp.done) begin
          np_q <= div_rsp.quotient[lcs_pkg::OpndW-1:0];
        end
      end
      lcs_pkg::ST_SMOD_DIV: begin
        if (div_rsp.done) begin
          smod_q <= smod_d;
        end
      end
      lcs_pkg::ST_MUL: begin
        if (mul_rsp.done) begin
          solv_q <= 1'b1;
          sol_q  <= mul_rsp.result;
        end
      end
      default: ;
    endcase
  end

  assign out_o.solvable = solv_q;
  assign out_o.solution = sol_q;
  assign out_o.divisor  = gcd_q;

endmodule

### sv/lcs_checker.sv
// -----------------------------------------------------------------------------
// Linear congruence solver checker
// Port-level assertions on the solver's transactions, bound to the top level.
// -----------------------------------------------------------------------------
`include "linear_congruence_solver_defines.svh"

module lcs_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic                      out_solvable_i,
  input logic [lcs_pkg::OpndW-1:0] out_solution_i,
  input logic [lcs_pkg::OpndW-1:0] out_divisor_i
);

  // A pending result blocks new input transactions.
  `LCS_ASSERT_IMP(a_busy_while_result, out_valid_i, !in_ready_i, "input ready with result pending")

  // The solver drops ready right after taking an item.
  `LCS_ASSERT_NXT(a_one_item_at_once, in_valid_i && in_ready_i, !in_ready_i, "second item taken while busy")

  // An unsolvable congruence reports a zero solution.
  `LCS_ASSERT_IMP(a_unsolvable_zero, out_valid_i && !out_solvable_i, out_solution_i == '0, "nonzero solution on unsolvable item")

  // A solvable congruence always has a nonzero gcd.
  `LCS_ASSERT_IMP(a_solvable_gcd, out_valid_i && out_solvable_i, out_divisor_i != '0, "zero gcd on solvable item")

  // A stalled result holds until taken.
  `LCS_ASSERT_NXT(a_result_holds, out_valid_i && !out_ready_i, out_valid_i && $stable(out_solvable_i) && $stable(out_solution_i) && $stable(out_divisor_i), "stalled result changed")

endmodule

bind linear_congruence_solver lcs_checker u_lcs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_solvable_i (out_o.solvable),
  .out_solution_i (out_o.solution),
  .out_divisor_i  (out_o.divisor)
);

### bench/testbench.sv
// -----------------------------------------------------------------------------
// Linear congruence solver testbench
// Sends congruences a*x = b (mod n) through the input channel. Directed
// corner cases come first, then random ones. An extended Euclid model inside
// the bench predicts each answer, and every answer that comes back is
// compared with the oldest prediction. Both channels stall in random bursts.
// -----------------------------------------------------------------------------
module testbench;

  typedef logic signed [lcs_pkg::OpndW:0] tgt_t;

  typedef struct {
    lcs_pkg::opnd_t multiplier;
    tgt_t           target;
    lcs_pkg::opnd_t modulus;
  } congruence_t;

  typedef struct {
    logic           solvable;
    lcs_pkg::opnd_t solution;
    lcs_pkg::opnd_t divisor;
  } answer_t;

  localparam int unsigned    RandomEqs  = 370;
  localparam int unsigned    QuietTail  = 40;
  localparam int unsigned    StallLimit = 10000;
  localparam int unsigned    DrainWait  = 100;
  localparam lcs_pkg::opnd_t OpndMax    = '1;

  logic clk_i;
  logic rst_ni;

  lcs_in_if  in_ch ();
  lcs_out_if out_ch ();

  linear_congruence_solver dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  congruence_t pending_eqs[$];
  answer_t     expected_answers[$];
  int unsigned mismatches = 0;
  int unsigned send_idle = 0;
  int unsigned take_idle = 0;
  int unsigned idle_cycles = 0;

  // Clock generation.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Extended Euclid on a and n, then x = s * (b / g) mod (n / g).
  function automatic answer_t solve_congruence(lcs_pkg::opnd_t a, tgt_t b,
                                               lcs_pkg::opnd_t n);
    logic [63:0] r_old, r_new, quo, rem, n_red, b_raw, b_mag, s_red, b_red;
    longint      s_old, s_new, s_next;
    answer_t     ans;
    ans = '{1'b0, '0, '0};
    if (n == '0) return ans;
    r_old = 64'(a);
    r_new = 64'(n);
    s_old = 1;
    s_new = 0;
    while (r_new != 0) begin
      quo = r_old / r_new;
      rem = r_old % r_new;
      s_next = s_old - longint'(quo) * s_new;
      r_old = r_new;
      r_new = rem;
      s_old = s_new;
      s_new = s_next;
    end
    ans.divisor = lcs_pkg::opnd_t'(r_old);
    // Target magnitude, up to 2^OpndW for the most negative value.
    b_raw = '0;
    b_raw[lcs_pkg::OpndW:0] = b;
    b_mag = b[lcs_pkg::OpndW] ? ((64'd1 << (lcs_pkg::OpndW + 1)) - b_raw) : b_raw;
    if (b_mag % r_old != 0) return ans;
    n_red = 64'(n) / r_old;
    // Reduce the Bezout coefficient and the scaled target into [0, n/g).
    if (s_old < 0) begin
      rem = $unsigned(-s_old) % n_red;
      s_red = (rem == 0) ? 64'd0 : n_red - rem;
    end else begin
      s_red = $unsigned(s_old) % n_red;
    end
    rem = (b_mag / r_old) % n_red;
    b_red = (b[lcs_pkg::OpndW] && rem != 0) ? n_red - rem : rem;
    ans.solvable = 1'b1;
    ans.solution = lcs_pkg::opnd_t'((s_red * b_red) % n_red);
    return ans;
  endfunction

  function automatic tgt_t make_target(logic [63:0] mag, logic neg);
    tgt_t val;
    val = tgt_t'(mag);
    return neg ? -val : val;
  endfunction

  task automatic add_eq(lcs_pkg::opnd_t a, tgt_t b, lcs_pkg::opnd_t n);
    congruence_t eq;
    eq.multiplier = a;
    eq.target = b;
    eq.modulus = n;
    pending_eqs.push_back(eq);
  endtask

  // Input driver: presents queued congruences, with random idle bursts.
  always @(posedge clk_i) begin : eq_driver
    congruence_t nxt;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_answers.push_back(
          solve_congruence(in_ch.multiplier, in_ch.target, in_ch.modulus));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_idle > 0) begin
          send_idle--;
          in_ch.valid <= 1'b0;
        end else if (pending_eqs.size() > QuietTail && $urandom_range(0, 3) == 0) begin
          send_idle = $urandom_range(0, 18);
          in_ch.valid <= 1'b0;
        end else if (pending_eqs.size() > 0) begin
          nxt = pending_eqs.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.multiplier <= nxt.multiplier;
          in_ch.target <= nxt.target;
          in_ch.modulus <= nxt.modulus;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each answer against the oldest prediction.
  always @(posedge clk_i) begin : answer_monitor
    answer_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_answers.size() == 0) begin
          $error("unexpected transaction: solvable %0b solution %0d divisor %0d",
                 out_ch.solvable, out_ch.solution, out_ch.divisor);
          mismatches++;
        end else begin
          want = expected_answers.pop_front();
          if (out_ch.solvable !== want.solvable) begin
            $error("solvable: expected %0b, got %0b", want.solvable, out_ch.solvable);
            mismatches++;
          end
          if (out_ch.solution !== want.solution) begin
            $error("solution: expected %0d, got %0d", want.solution, out_ch.solution);
            mismatches++;
          end
          if (out_ch.divisor !== want.divisor) begin
            $error("divisor: expected %0d, got %0d", want.divisor, out_ch.divisor);
            mismatches++;
          end
        end
      end
      if (take_idle > 0) begin
        take_idle--;
        out_ch.ready <= 1'b0;
      end else if (pending_eqs.size() > QuietTail && $urandom_range(0, 9) == 0) begin
        take_idle = $urandom_range(0, 18);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when no transaction completes for too long.
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin : stimulus
    lcs_pkg::opnd_t fib[0:47];
    lcs_pkg::opnd_t edge_vals[0:7];
    lcs_pkg::opnd_t a, n, g;
    logic [63:0]    mag;
    int unsigned    kind, idx;

    in_ch.valid = 1'b0;
    in_ch.multiplier = '0;
    in_ch.target = '0;
    in_ch.modulus = '0;
    out_ch.ready = 1'b0;
    rst_ni = 1'b0;

    fib[0] = 1;
    fib[1] = 1;
    for (int i = 2; i < 48; i++) fib[i] = fib[i-1] + fib[i-2];
    edge_vals = '{lcs_pkg::opnd_t'(0), lcs_pkg::opnd_t'(1), lcs_pkg::opnd_t'(2),
                  OpndMax, OpndMax - 1,
                  lcs_pkg::opnd_t'(1) << (lcs_pkg::OpndW - 1),
                  (lcs_pkg::opnd_t'(1) << (lcs_pkg::OpndW - 1)) - 1,
                  lcs_pkg::opnd_t'(3)};

    // Directed corner cases.
    add_eq(0, 0, 1);
    add_eq(0, 12, 4);                              // zero multiplier, solvable
    add_eq(0, 13, 4);                              // zero multiplier, no solution
    add_eq(5, 7, 0);                               // zero modulus
    add_eq(0, 0, 0);
    add_eq(3, 1, 7);
    add_eq(4, 6, 10);
    add_eq(4, 5, 10);
    add_eq(4, -6, 10);
    add_eq(OpndMax, make_target(64'(OpndMax), 1'b0), OpndMax);
    add_eq(OpndMax, make_target(64'(OpndMax), 1'b1), OpndMax);
    // Most negative target.
    add_eq(1, make_target(64'd1 << lcs_pkg::OpndW, 1'b1), OpndMax);
    add_eq(6, make_target(64'd1 << lcs_pkg::OpndW, 1'b1), 4);
    add_eq(OpndMax - 1, make_target(64'd1 << lcs_pkg::OpndW, 1'b1), OpndMax);
    add_eq(fib[46], 1, fib[45]);                   // longest Euclid chain
    add_eq(fib[45], -1, fib[46]);
    add_eq(OpndMax, 1, 1);
    add_eq(lcs_pkg::opnd_t'(1) << (lcs_pkg::OpndW - 1),
           make_target(64'd1 << (lcs_pkg::OpndW - 1), 1'b0), OpndMax - 1);
    add_eq(12, 18, OpndMax - 3);
    add_eq(7, 0, OpndMax);

    // Random congruences.
    for (int i = 0; i < RandomEqs; i++) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2: begin
          add_eq($urandom, tgt_t'({$urandom_range(0, 1), $urandom}), $urandom);
        end
        3, 4, 5: begin
          // Shared factor between a and n, target mostly a multiple of it.
          g = $urandom_range(1, 1 << $urandom_range(0, 16));
          a = g * $urandom_range(0, OpndMax / g);
          n = g * $urandom_range(1, OpndMax / g);
          if ($urandom_range(0, 4) != 0) begin
            mag = 64'(g) * $urandom_range(0, OpndMax / g);
            add_eq(a, make_target(mag, $urandom_range(0, 1)), n);
          end else begin
            add_eq(a, tgt_t'({$urandom_range(0, 1), $urandom}), n);
          end
        end
        6: begin
          add_eq($urandom_range(0, 20), tgt_t'($signed($urandom_range(0, 80)) - 40),
                 $urandom_range(1, 20));
        end
        7: begin
          idx = $urandom_range(1, 46);
          if ($urandom_range(0, 1) == 1)
            add_eq(fib[idx], tgt_t'({$urandom_range(0, 1), $urandom}), fib[idx-1]);
          else
            add_eq(fib[idx-1], tgt_t'({$urandom_range(0, 1), $urandom}), fib[idx]);
        end
        8: begin
          n = edge_vals[$urandom_range(0, 7)];
          add_eq(edge_vals[$urandom_range(0, 7)],
                 tgt_t'({$urandom_range(0, 1), edge_vals[$urandom_range(0, 7)]}),
                 (n == '0) ? lcs_pkg::opnd_t'(1) : n);
        end
        default: begin
          add_eq($urandom, tgt_t'({$urandom_range(0, 1), $urandom}),
                 ($urandom_range(0, 2) == 0) ? lcs_pkg::opnd_t'(0) : lcs_pkg::opnd_t'(1));
        end
      endcase
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (pending_eqs.size() == 0 && !in_ch.valid && expected_answers.size() == 0);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
